>>> rtl/core/ftd_pkg.sv
// Shared types, codes and reset values of the flow trickle detector.
package ftd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 40;

    localparam logic [CFG_INDEX_W-1:0] CFG_SMALL_READ_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_FLOOR        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_CEILING      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STREAK_THRESHOLD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTE_CAP         = 3'd4;

    localparam logic [15:0] RST_SMALL_READ_LIMIT = 16'd4;
    localparam logic [39:0] RST_GAP_FLOOR        = 40'd1500000000;
    localparam logic [39:0] RST_GAP_CEILING      = 40'd60000000000;
    localparam logic [7:0]  RST_STREAK_THRESHOLD = 8'd10;
    localparam logic [31:0] RST_BYTE_CAP         = 32'd65535;

    typedef enum logic [2:0] {
        OUT_IGNORED = 3'd0,
        OUT_NEW     = 3'd1,
        OUT_UPDATED = 3'd2,
        OUT_DROPPED = 3'd3,
        OUT_FLAGGED = 3'd4
    } ftd_outcome_t;

    typedef struct packed {
        logic [15:0] small_read_limit;
        logic [39:0] gap_floor;
        logic [39:0] gap_ceiling;
        logic [7:0]  streak_threshold;
        logic [31:0] byte_cap;
    } ftd_cfg_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [15:0] port;
        logic [63:0] last_time;
        logic [7:0]  streak;
        logic [31:0] total;
    } ftd_flow_t;

endpackage

>>> rtl/core/ftd_ram.sv
// Generic simple dual-port RAM with registered read.
module ftd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/core/ftd_cfg.sv
// Configuration register file of the flow trickle detector.
module ftd_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ftd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ftd_pkg::CFG_DATA_W-1:0]      cfg_data,
    output ftd_pkg::ftd_cfg_t                   cfg
);

    ftd_pkg::ftd_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.small_read_limit <= ftd_pkg::RST_SMALL_READ_LIMIT;
            cfg_reg.gap_floor        <= ftd_pkg::RST_GAP_FLOOR;
            cfg_reg.gap_ceiling      <= ftd_pkg::RST_GAP_CEILING;
            cfg_reg.streak_threshold <= ftd_pkg::RST_STREAK_THRESHOLD;
            cfg_reg.byte_cap         <= ftd_pkg::RST_BYTE_CAP;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ftd_pkg::CFG_SMALL_READ_LIMIT: cfg_reg.small_read_limit <= cfg_data[15:0];
                ftd_pkg::CFG_GAP_FLOOR:        cfg_reg.gap_floor        <= cfg_data[39:0];
                ftd_pkg::CFG_GAP_CEILING:      cfg_reg.gap_ceiling      <= cfg_data[39:0];
                ftd_pkg::CFG_STREAK_THRESHOLD: cfg_reg.streak_threshold <= cfg_data[7:0];
                ftd_pkg::CFG_BYTE_CAP:         cfg_reg.byte_cap         <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/ftd_seq.sv
// Sequencer and shared scan/compare datapath over the flow table RAM.
module ftd_seq #(
    parameter int FLOW_ENTRIES = 64,
    parameter int IDX_W        = 6,
    parameter int WORD_W       = 159
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ftd_pkg::ftd_cfg_t       cfg,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [31:0]             peer_address,
    input  logic [15:0]             peer_port,
    input  logic signed [31:0]      read_length,
    input  logic [63:0]             timestamp_ns,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              outcome,
    output logic [31:0]             flagged_address,
    output logic                    evicted,
    output logic [7:0]              streak_now,
    output logic                    ram_wr_en,
    output logic [IDX_W-1:0]        ram_wr_addr,
    output logic [WORD_W-1:0]       ram_wr_data,
    output logic [IDX_W-1:0]        ram_rd_addr,
    input  logic [WORD_W-1:0]       ram_rd_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SEARCH,
        S_PICK,
        S_CALC,
        S_EVAL,
        S_TOUCH,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [IDX_W-1:0]    iss_reg;
    logic                iss_done_reg;
    logic                chk_valid_reg;
    logic [IDX_W-1:0]    chk_idx_reg;

    logic [31:0]         addr_reg;
    logic [15:0]         port_reg;
    logic [31:0]         len_reg;
    logic [63:0]         now_reg;
    logic                small_reg;

    logic                found_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    ftd_pkg::ftd_flow_t  hit_flow_reg;
    logic [IDX_W-1:0]    hit_rec_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [IDX_W-1:0]    free_rec_reg;
    logic [IDX_W-1:0]    lru_idx_reg;
    logic [IDX_W-1:0]    lru_rec_reg;

    logic [IDX_W-1:0]    tgt_idx_reg;
    logic [IDX_W-1:0]    tgt_rec_reg;
    ftd_pkg::ftd_flow_t  new_flow_reg;
    logic [63:0]         gap_reg;
    logic [32:0]         sum_reg;

    logic [2:0]          res_outcome_reg;
    logic [31:0]         res_addr_reg;
    logic                res_evicted_reg;
    logic [7:0]          res_streak_reg;

    logic                out_valid_reg;
    logic [2:0]          outcome_reg;
    logic [31:0]         flagged_address_reg;
    logic                evicted_reg;
    logic [7:0]          streak_now_reg;

    ftd_pkg::ftd_flow_t  rd_flow;
    logic [IDX_W-1:0]    rd_rec;
    logic                ignored;
    logic                is_small;
    logic                is_hit;
    logic                over_cap;
    logic                gap_ok;
    logic [7:0]          streak_c;
    logic                flag_c;

    assign rd_flow  = ftd_pkg::ftd_flow_t'(ram_rd_data[WORD_W-1:IDX_W]);
    assign rd_rec   = ram_rd_data[IDX_W-1:0];
    assign ignored  = read_length[31] || (read_length == 32'sd0) || (peer_port == 16'd0);
    assign is_small = $unsigned(read_length) <= {16'd0, cfg.small_read_limit};
    assign is_hit   = rd_flow.valid && (rd_flow.address == addr_reg)
                      && (rd_flow.port == port_reg);

    assign over_cap = sum_reg > {1'b0, cfg.byte_cap};
    assign gap_ok   = small_reg && (gap_reg >= {24'd0, cfg.gap_floor})
                      && (gap_reg <= {24'd0, cfg.gap_ceiling});
    assign streak_c = !gap_ok ? 8'd0 :
                      (hit_flow_reg.streak == 8'hFF) ? 8'hFF : hit_flow_reg.streak + 8'd1;
    assign flag_c   = streak_c >= cfg.streak_threshold;

    always_comb
    begin
        ram_rd_addr = iss_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = iss_reg;
        ram_wr_data = {{(WORD_W-IDX_W){1'b0}}, iss_reg};
        case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en = 1'b1;
            end
            S_TOUCH:
            begin
                ram_wr_en   = chk_valid_reg;
                ram_wr_addr = chk_idx_reg;
                if (chk_idx_reg == tgt_idx_reg)
                begin
                    ram_wr_data = {new_flow_reg, {IDX_W{1'b0}}};
                end
                else if (rd_rec < tgt_rec_reg)
                begin
                    ram_wr_data = {rd_flow, rd_rec + IDX_W'(1)};
                end
                else
                begin
                    ram_wr_data = {rd_flow, rd_rec};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_CLEAR;
            iss_reg             <= '0;
            iss_done_reg        <= 1'b0;
            chk_valid_reg       <= 1'b0;
            chk_idx_reg         <= '0;
            addr_reg            <= '0;
            port_reg            <= '0;
            len_reg             <= '0;
            now_reg             <= '0;
            small_reg           <= 1'b0;
            found_reg           <= 1'b0;
            hit_idx_reg         <= '0;
            hit_flow_reg        <= '0;
            hit_rec_reg         <= '0;
            free_found_reg      <= 1'b0;
            free_idx_reg        <= '0;
            free_rec_reg        <= '0;
            lru_idx_reg         <= '0;
            lru_rec_reg         <= '0;
            tgt_idx_reg         <= '0;
            tgt_rec_reg         <= '0;
            new_flow_reg        <= '0;
            gap_reg             <= '0;
            sum_reg             <= '0;
            res_outcome_reg     <= ftd_pkg::OUT_IGNORED;
            res_addr_reg        <= '0;
            res_evicted_reg     <= 1'b0;
            res_streak_reg      <= '0;
            out_valid_reg       <= 1'b0;
            outcome_reg         <= ftd_pkg::OUT_IGNORED;
            flagged_address_reg <= '0;
            evicted_reg         <= 1'b0;
            streak_now_reg      <= '0;
        end
        else
        begin
            if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    if (iss_reg == LAST_IDX)
                    begin
                        iss_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        iss_reg <= iss_reg + IDX_W'(1);
                    end
                end

                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        addr_reg       <= peer_address;
                        port_reg       <= peer_port;
                        len_reg        <= $unsigned(read_length);
                        now_reg        <= timestamp_ns;
                        small_reg      <= is_small;
                        found_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        iss_reg        <= '0;
                        iss_done_reg   <= 1'b0;
                        chk_valid_reg  <= 1'b0;
                        if (ignored)
                        begin
                            res_outcome_reg <= ftd_pkg::OUT_IGNORED;
                            res_addr_reg    <= '0;
                            res_evicted_reg <= 1'b0;
                            res_streak_reg  <= '0;
                            state_reg       <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SEARCH;
                        end
                    end
                end

                S_SEARCH, S_TOUCH:
                begin
                    chk_valid_reg <= !iss_done_reg;
                    chk_idx_reg   <= iss_reg;
                    if (!iss_done_reg)
                    begin
                        if (iss_reg == LAST_IDX)
                        begin
                            iss_done_reg <= 1'b1;
                        end
                        else
                        begin
                            iss_reg <= iss_reg + IDX_W'(1);
                        end
                    end

                    if (chk_valid_reg && state_reg == S_SEARCH)
                    begin
                        if (is_hit && !found_reg)
                        begin
                            found_reg    <= 1'b1;
                            hit_idx_reg  <= chk_idx_reg;
                            hit_flow_reg <= rd_flow;
                            hit_rec_reg  <= rd_rec;
                        end
                        if (!rd_flow.valid && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= chk_idx_reg;
                            free_rec_reg   <= rd_rec;
                        end
                        if (chk_idx_reg == '0 || rd_rec >= lru_rec_reg)
                        begin
                            lru_idx_reg <= chk_idx_reg;
                            lru_rec_reg <= rd_rec;
                        end
                    end

                    if (chk_valid_reg && chk_idx_reg == LAST_IDX)
                    begin
                        state_reg <= (state_reg == S_SEARCH) ? S_PICK : S_DONE;
                    end
                end

                S_PICK:
                begin
                    iss_reg       <= '0;
                    iss_done_reg  <= 1'b0;
                    chk_valid_reg <= 1'b0;
                    if (found_reg)
                    begin
                        tgt_idx_reg <= hit_idx_reg;
                        tgt_rec_reg <= hit_rec_reg;
                        state_reg   <= S_CALC;
                    end
                    else
                    begin
                        tgt_idx_reg            <= free_found_reg ? free_idx_reg : lru_idx_reg;
                        tgt_rec_reg            <= free_found_reg ? free_rec_reg : lru_rec_reg;
                        new_flow_reg.valid     <= 1'b1;
                        new_flow_reg.address   <= addr_reg;
                        new_flow_reg.port      <= port_reg;
                        new_flow_reg.last_time <= now_reg;
                        new_flow_reg.streak    <= {7'd0, small_reg};
                        new_flow_reg.total     <= len_reg;
                        res_outcome_reg        <= ftd_pkg::OUT_NEW;
                        res_addr_reg           <= '0;
                        res_evicted_reg        <= !free_found_reg;
                        res_streak_reg         <= {7'd0, small_reg};
                        state_reg              <= S_TOUCH;
                    end
                end

                S_CALC:
                begin
                    gap_reg   <= now_reg - hit_flow_reg.last_time;
                    sum_reg   <= {1'b0, hit_flow_reg.total} + {1'b0, len_reg};
                    state_reg <= S_EVAL;
                end

                S_EVAL:
                begin
                    res_evicted_reg <= 1'b0;
                    if (over_cap)
                    begin
                        new_flow_reg    <= {1'b0, hit_flow_reg.address, hit_flow_reg.port,
                                            hit_flow_reg.last_time, hit_flow_reg.streak,
                                            hit_flow_reg.total};
                        res_outcome_reg <= ftd_pkg::OUT_DROPPED;
                        res_addr_reg    <= '0;
                        res_streak_reg  <= '0;
                    end
                    else if (flag_c)
                    begin
                        new_flow_reg    <= {1'b0, hit_flow_reg.address, hit_flow_reg.port,
                                            hit_flow_reg.last_time, hit_flow_reg.streak,
                                            hit_flow_reg.total};
                        res_outcome_reg <= ftd_pkg::OUT_FLAGGED;
                        res_addr_reg    <= addr_reg;
                        res_streak_reg  <= '0;
                    end
                    else
                    begin
                        new_flow_reg.valid     <= 1'b1;
                        new_flow_reg.address   <= hit_flow_reg.address;
                        new_flow_reg.port      <= hit_flow_reg.port;
                        new_flow_reg.last_time <= now_reg;
                        new_flow_reg.streak    <= streak_c;
                        new_flow_reg.total     <= sum_reg[31:0];
                        res_outcome_reg        <= ftd_pkg::OUT_UPDATED;
                        res_addr_reg           <= '0;
                        res_streak_reg         <= streak_c;
                    end
                    state_reg <= S_TOUCH;
                end

                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        outcome_reg         <= res_outcome_reg;
                        flagged_address_reg <= res_addr_reg;
                        evicted_reg         <= res_evicted_reg;
                        streak_now_reg      <= res_streak_reg;
                        state_reg           <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign outcome         = outcome_reg;
    assign flagged_address = flagged_address_reg;
    assign evicted         = evicted_reg;
    assign streak_now      = streak_now_reg;

endmodule

>>> rtl/core/flow_trickle_detector.sv
// Top level of the flow trickle detector: config registers, sequencer, flow table RAM.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------------
//  in      | input     | in_valid / in_stall  | peer_address, peer_port, read_length,
//          |           |                     | timestamp_ns
//  out     | output    | out_valid/out_stall | outcome, flagged_address, evicted, streak_now
//  cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// A tracked item makes one lookup sweep and one recency update sweep over the flow table RAM,
// one entry per cycle on its read port. An ignored item skips both sweeps. After reset a
// clearing pass over every entry initializes the table; no item is taken meanwhile,
// configuration writes are. A finished item waits in the output register while the
// next item is taken.
module flow_trickle_detector #(
    parameter int FLOW_ENTRIES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [31:0]                         peer_address,
    input  logic [15:0]                         peer_port,
    input  logic signed [31:0]                  read_length,
    input  logic [63:0]                         timestamp_ns,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          outcome,
    output logic [31:0]                         flagged_address,
    output logic                                evicted,
    output logic [7:0]                          streak_now,
    input  logic                                cfg_write,
    input  logic [ftd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ftd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int IDX_W  = $clog2(FLOW_ENTRIES > 1 ? FLOW_ENTRIES : 2);
    localparam int WORD_W = $bits(ftd_pkg::ftd_flow_t) + IDX_W;

    ftd_pkg::ftd_cfg_t   cfg;
    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [WORD_W-1:0]   ram_wr_data;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic [WORD_W-1:0]   ram_rd_data;

    ftd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ftd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (FLOW_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ftd_seq #(
        .FLOW_ENTRIES (FLOW_ENTRIES),
        .IDX_W        (IDX_W),
        .WORD_W       (WORD_W)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .peer_address    (peer_address),
        .peer_port       (peer_port),
        .read_length     (read_length),
        .timestamp_ns    (timestamp_ns),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .outcome         (outcome),
        .flagged_address (flagged_address),
        .evicted         (evicted),
        .streak_now      (streak_now),
        .ram_wr_en       (ram_wr_en),
        .ram_wr_addr     (ram_wr_addr),
        .ram_wr_data     (ram_wr_data),
        .ram_rd_addr     (ram_rd_addr),
        .ram_rd_data     (ram_rd_data)
    );

endmodule
